[design/mpoc_pkg.sv]
package mpoc_pkg;

   localparam int SLOTS            = 4;
   localparam int OUT_COUNT_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 64;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   // item kinds
   localparam logic KIND_TEXT  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_A = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_B = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_C = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PATTERN_D = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH_A  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH_B  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH_C  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH_D  = 3'd7;

   typedef struct packed {
      logic       kind;
      logic [7:0] text_byte;
   } req_type;

   typedef struct packed {
      logic [OUT_COUNT_WIDTH-1:0] count_a;
      logic [OUT_COUNT_WIDTH-1:0] count_b;
      logic [OUT_COUNT_WIDTH-1:0] count_c;
      logic [OUT_COUNT_WIDTH-1:0] count_d;
   } rsp_type;

endpackage

[design/multi_pattern_occurrence_counter.sv]
// Channel   Ports                               Direction  Moves
// req       req_valid  req_stall  req_data      in         one text byte or clear command
// rsp       rsp_valid  rsp_stall  rsp_data      out        all four counts after the item
// csr       csr_write  csr_index  csr_wdata     in         pattern and length registers
//
// One transaction per cycle while req_stall is low: the window compare, count update and result
// all happen in the accepting cycle; the result is registered in the output register, or in the
// one-entry skid behind it if the output register is held, so req_stall rises only when both
// are full; a stalled result holds in place.
// Reset (synchronous) clears counts, line fill, pattern lengths and both output entries.
module multi_pattern_occurrence_counter #(
   parameter int NUM_PATTERNS    = 4,
   parameter int MAX_PATTERN_LEN = 8,
   parameter int COUNT_WIDTH     = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  mpoc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output mpoc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_write,
   input  logic [mpoc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mpoc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import mpoc_pkg::*;

   localparam int PAT_W  = 8 * MAX_PATTERN_LEN;
   localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);

   logic [PAT_W-1:0]       pattern_ff [NUM_PATTERNS];
   logic [3:0]             length_ff  [NUM_PATTERNS];

   logic [7:0]             win_ff [MAX_PATTERN_LEN];
   logic [7:0]             win_in [MAX_PATTERN_LEN];
   logic [FILL_W-1:0]      fill_ff, fill_in;

   logic [COUNT_WIDTH-1:0] count_ff [NUM_PATTERNS];
   logic [COUNT_WIDTH-1:0] count_in [NUM_PATTERNS];
   logic [NUM_PATTERNS-1:0] hit;

   logic [OUT_COUNT_WIDTH-1:0] out_count [SLOTS];
   rsp_type                rsp_new;

   rsp_type                out_ff, out_in, skid_ff, skid_in;
   logic                   out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;

   logic                   accept, out_fire, is_clear, is_newline;

   assign req_stall = skid_vld_ff;
   assign accept    = req_valid & ~skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
   assign out_fire  = out_vld_ff & ~rsp_stall;

   assign is_clear   = (req_data.kind == KIND_CLEAR);
   assign is_newline = (req_data.kind == KIND_TEXT) && (req_data.text_byte == NEWLINE_BYTE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_PATTERNS; s++) begin
            pattern_ff[s] <= '0;
            length_ff[s]  <= '0;
         end
      end else if (csr_write) begin
         for (int s = 0; s < NUM_PATTERNS; s++) begin
            if (csr_index == CSR_INDEX_WIDTH'(CSR_PATTERN_A + s)) begin
               pattern_ff[s] <= csr_wdata[PAT_W-1:0];
            end
            if (csr_index == CSR_INDEX_WIDTH'(CSR_LENGTH_A + s)) begin
               length_ff[s] <= csr_wdata[3:0];
            end
         end
      end
   end

   // window shift, newest byte at index 0
   always_comb begin
      win_in[0] = req_data.text_byte;
      for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
         win_in[i] = win_ff[i-1];
      end
      if (is_clear || is_newline) begin
         fill_in = '0;
      end else if (fill_ff < FILL_W'(MAX_PATTERN_LEN)) begin
         fill_in = fill_ff + 1'b1;
      end else begin
         fill_in = fill_ff;
      end
   end

   // parallel compare of every slot against the shifted window
   always_comb begin
      logic all_eq;
      all_eq = 1'b0;
      for (int s = 0; s < NUM_PATTERNS; s++) begin
         hit[s] = 1'b0;
         for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
            all_eq = 1'b1;
            for (int k = 0; k < l; k++) begin
               if (win_in[l-1-k] != pattern_ff[s][8*k +: 8]) begin
                  all_eq = 1'b0;
               end
            end
            if (length_ff[s] == 4'(l) && fill_in >= FILL_W'(l) && all_eq) begin
               hit[s] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
         if (is_clear) begin
            count_in[s] = '0;
         end else if (!is_newline && hit[s] && count_ff[s] != {COUNT_WIDTH{1'b1}}) begin
            count_in[s] = count_ff[s] + 1'b1;
         end else begin
            count_in[s] = count_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int s = 0; s < NUM_PATTERNS; s++) begin
            count_ff[s] <= '0;
         end
      end else if (accept) begin
         fill_ff <= fill_in;
         for (int s = 0; s < NUM_PATTERNS; s++) begin
            count_ff[s] <= count_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_clear && !is_newline) begin
         for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // result: counts shown as 32 bits, unused slots read zero
   always_comb begin
      logic [63:0] wide;
      wide = '0;
      for (int s = 0; s < SLOTS; s++) begin
         out_count[s] = '0;
      end
      for (int s = 0; s < NUM_PATTERNS; s++) begin
         wide         = 64'(count_in[s]);
         out_count[s] = wide[OUT_COUNT_WIDTH-1:0];
      end
      rsp_new.count_a = out_count[0];
      rsp_new.count_b = out_count[1];
      rsp_new.count_c = out_count[2];
      rsp_new.count_d = out_count[3];
   end

   // output register with one skid entry
   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (out_fire) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_vld_ff || out_fire) begin
            out_in     = rsp_new;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = rsp_new;
            skid_vld_in = 1'b1;
         end
      end else if (out_fire) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule
